@@ hdl/mjt_pkg.sv @@
// ----------------------------------------------------------------------------
// Minimum-jerk trajectory package
// Shared widths, pipeline depths, status codes and the saturation helper
// for the quintic trajectory sampler and its pipelined divider.
// ----------------------------------------------------------------------------
package mjt_pkg;

  // Fraction bits of the position format.
  localparam int FRAC_BITS = 20;

  // Fraction bits of the normalized time s.
  localparam int S_BITS = 30;

  // Field widths.
  localparam int POS_W  = 24;
  localparam int TIME_W = 26;
  localparam int RATE_W = 32;
  localparam int STAT_W = 2;

  // Internal widths.
  localparam int S_W     = S_BITS + 1;            // s in [0, 2^30]
  localparam int AD_W    = POS_W;                 // |end - start|
  localparam int DDP_W   = 33;                    // |ddp| magnitude
  localparam int PP_W    = AD_W + S_W;            // |d| * p
  localparam int AP_W    = AD_W + DDP_W;          // |d| * |ddp|
  localparam int K_W     = 14;                    // width of 5^6
  localparam int VN_W    = PP_W + K_W;            // |d| * dp * 5^6
  localparam int VSUM_W  = VN_W + 1;
  localparam int VM_W    = VSUM_W - (FRAC_BITS + 8);
  localparam int AN1_W   = AP_W + K_W;
  localparam int AN2_W   = AN1_W + K_W;           // |d| * |ddp| * 5^12
  localparam int ASUM_W  = AN2_W + 1;
  localparam int AX_W    = ASUM_W - (FRAC_BITS + 2);
  localparam int TSQ_W   = 2 * TIME_W;

  // Divider geometry: quotient bits, divisor and dividend widths.
  localparam int DIV_Q_W   = 33;
  localparam int DIV_DEN_W = TSQ_W;
  localparam int DIV_NUM_W = (AX_W > (TIME_W + S_BITS)) ? AX_W : (TIME_W + S_BITS);
  localparam int DIV_LAT   = DIV_Q_W + 1;

  // Constant factor 5^6; 5^12 is applied as two such steps.
  localparam logic [K_W-1:0] K5_6 = K_W'(15625);

  // Pipeline depths, counted in register stages after the request edge.
  localparam int D_PRE  = 2;
  localparam int D_S    = D_PRE + DIV_LAT;
  localparam int D_POLY = D_S + 5;
  localparam int D_PROD = D_POLY + 1;
  localparam int D_MUL1 = D_PROD + 1;
  localparam int D_MUL2 = D_MUL1 + 1;
  localparam int D_NUM  = D_MUL2 + 1;
  localparam int D_RATE = D_NUM + DIV_LAT;
  localparam int D_OUT  = D_RATE + 1;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_CLAMPED  = 2'd1,
    ST_ZERO_DUR = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  // Side band that follows a request from the front end to the output.
  typedef struct packed {
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
    logic [AD_W-1:0]  ad;
    logic             dneg;
    logic             clamped;
    logic             zero;
  } sb_t;

  // Late side band: finished position and acceleration sign.
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             aneg;
  } late_t;

  // Apply a sign to a quotient magnitude and saturate to 32 bits.
  // Returns {saturated, value}.
  function automatic logic [RATE_W:0] sat_rate(input logic [DIV_Q_W-1:0] mag,
                                               input logic ovf,
                                               input logic neg_in);
    logic neg;
    logic [RATE_W:0] res;
    neg = neg_in && (ovf || (mag != '0));
    if (neg) begin
      if (ovf || (mag > DIV_Q_W'(33'h080000000))) begin
        res = {1'b1, 32'h80000000};
      end else begin
        res = {1'b0, RATE_W'(DIV_Q_W'(0) - mag)};
      end
    end else begin
      if (ovf || (mag > DIV_Q_W'(33'h07FFFFFFF))) begin
        res = {1'b1, 32'h7FFFFFFF};
      end else begin
        res = {1'b0, mag[RATE_W-1:0]};
      end
    end
    return res;
  endfunction

endpackage

@@ hdl/min_jerk_joint_trajectory_unit.sv @@
// ----------------------------------------------------------------------------
// Minimum-jerk joint trajectory unit
// Samples the quintic minimum-jerk profile for one joint per request and
// returns position, velocity and acceleration with a status code.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   request  | start / busy           | in_start_pos, in_end_pos, in_time_us
//   result   | out_strobe (one cycle) | out_position, out_velocity,
//            |                        | out_acceleration, out_status
//   config   | cfg_valid / cfg_ready  | cfg_duration_us
//
// A request is taken every cycle while busy is low; results return in order.
// The latency is set by three 34-stage pipelined dividers, one for s and two
// in parallel for the rates, plus the chain of four power multipliers.
// busy is high only while rst_n is low; reset clears all valid bits.
// Results cannot be held off, so there is no stall path in the pipeline.
// ----------------------------------------------------------------------------
module min_jerk_joint_trajectory_unit
  import mjt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [POS_W-1:0]  in_start_pos,
  input  logic signed [POS_W-1:0]  in_end_pos,
  input  logic [TIME_W-1:0]        in_time_us,
  output logic                     out_strobe,
  output logic signed [POS_W-1:0]  out_position,
  output logic signed [RATE_W-1:0] out_velocity,
  output logic signed [RATE_W-1:0] out_acceleration,
  output logic [STAT_W-1:0]        out_status,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [TIME_W-1:0]        cfg_duration_us
);

  localparam logic [TIME_W-1:0] DUR_RESET = TIME_W'(1000000);
  localparam logic [PP_W-1:0]   HALF_S    = PP_W'(1) << (S_BITS - 1);

  // Configuration and valid chain.
  logic [TIME_W-1:0] dur_r;
  logic [TSQ_W-1:0]  tsq_r;
  logic [D_OUT:1]    v_r;

  // Front end.
  logic [POS_W-1:0]  in_start_r, in_end_r;
  logic [TIME_W-1:0] in_time_r;
  logic [TIME_W-1:0] tc_r;
  sb_t               sb_nxt;
  sb_t               sb_r [D_PRE:D_RATE];
  logic signed [POS_W:0] d_full;

  // Normalized time and its powers.
  logic [DIV_Q_W-1:0] s_quo;
  logic               s_ovf;
  logic [S_W-1:0] s_37_r, s2_37_r;
  logic [S_W-1:0] s_38_r, s2_38_r, s3_38_r;
  logic [S_W-1:0] s_39_r, s2_39_r, s3_39_r, s4_39_r;
  logic [S_W-1:0] s_40_r, s2_40_r, s3_40_r, s4_40_r, s5_40_r;

  // Polynomials.
  logic signed [39:0] sx, s2x, s3x, s4x, s5x;
  logic signed [39:0] p_full, dp_full, ddp_full;
  logic [S_W-1:0]     p_nxt, dp_nxt;
  logic [DDP_W-1:0]   addr_nxt;
  logic [S_W-1:0]     p_41_r, dp_41_r;
  logic [DDP_W-1:0]   addr_41_r;
  logic               ddpneg_41_r;

  // Products and rate dividends.
  logic [PP_W-1:0]   pp_42_r, vp_42_r;
  logic [AP_W-1:0]   ap_42_r;
  logic              aneg_42_r, aneg_43_r;
  logic [AD_W-1:0]   pm_43_r;
  logic [VN_W-1:0]   vn_43_r;
  logic [AN1_W-1:0]  an1_43_r;
  logic [VM_W-1:0]   vm_44_r, vm_45_r;
  logic [AN2_W-1:0]  an2_44_r;
  logic [AX_W-1:0]   ax_45_r;
  logic [POS_W-1:0]  pos_nxt;
  late_t             late_r [D_MUL2:D_RATE];

  // Rate quotients and output stage.
  logic [DIV_Q_W-1:0] v_quo, a_quo;
  logic               v_ovf, a_ovf;
  logic [RATE_W:0]    v_sat, a_sat;
  sb_t                sb_end;
  late_t              late_end;
  logic [POS_W-1:0]   out_position_r;
  logic [RATE_W-1:0]  out_velocity_r, out_acceleration_r;
  status_t            out_status_r;

  assign busy      = !rst_n;
  assign cfg_ready = 1'b1;

  // Duration register and its square.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r <= DUR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dur_r <= cfg_duration_us;
    end
  end

  always_ff @(posedge clk) begin
    tsq_r <= TSQ_W'(dur_r) * TSQ_W'(dur_r);
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[D_OUT-1:1], start && !busy};
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    in_start_r <= in_start_pos;
    in_end_r   <= in_end_pos;
    in_time_r  <= in_time_us;
  end

  // Distance, clamped time and special-case flags.
  always_comb begin
    d_full            = $signed({in_end_r[POS_W-1], in_end_r})
                      - $signed({in_start_r[POS_W-1], in_start_r});
    sb_nxt.start_pos  = in_start_r;
    sb_nxt.end_pos    = in_end_r;
    sb_nxt.dneg       = d_full[POS_W];
    sb_nxt.ad         = d_full[POS_W] ? AD_W'(-d_full) : AD_W'(d_full);
    sb_nxt.clamped    = in_time_r > dur_r;
    sb_nxt.zero       = dur_r == '0;
  end

  always_ff @(posedge clk) begin
    sb_r[D_PRE] <= sb_nxt;
    tc_r        <= (in_time_r > dur_r) ? dur_r : in_time_r;
  end

  // Side band delay line.
  for (genvar k = D_PRE + 1; k <= D_RATE; k++) begin : g_sb
    always_ff @(posedge clk) begin
      sb_r[k] <= sb_r[k-1];
    end
  end

  // s = floor(tc * 2^30 / T).
  mjt_div u_div_s (
    .clk (clk),
    .num (DIV_NUM_W'({tc_r, S_BITS'(0)})),
    .den (DIV_DEN_W'(dur_r)),
    .quo (s_quo),
    .ovf (s_ovf)
  );

  // Powers of s, one multiply per stage.
  always_ff @(posedge clk) begin
    s_37_r  <= s_quo[S_W-1:0];
    s2_37_r <= S_W'(((2*S_W)'(s_quo[S_W-1:0]) * (2*S_W)'(s_quo[S_W-1:0])) >> S_BITS);
    s_38_r  <= s_37_r;
    s2_38_r <= s2_37_r;
    s3_38_r <= S_W'(((2*S_W)'(s2_37_r) * (2*S_W)'(s_37_r)) >> S_BITS);
    s_39_r  <= s_38_r;
    s2_39_r <= s2_38_r;
    s3_39_r <= s3_38_r;
    s4_39_r <= S_W'(((2*S_W)'(s3_38_r) * (2*S_W)'(s_38_r)) >> S_BITS);
    s_40_r  <= s_39_r;
    s2_40_r <= s2_39_r;
    s3_40_r <= s3_39_r;
    s4_40_r <= s4_39_r;
    s5_40_r <= S_W'(((2*S_W)'(s4_39_r) * (2*S_W)'(s_39_r)) >> S_BITS);
  end

  // Position, velocity and acceleration shape polynomials.
  always_comb begin
    sx       = $signed({9'b0, s_40_r});
    s2x      = $signed({9'b0, s2_40_r});
    s3x      = $signed({9'b0, s3_40_r});
    s4x      = $signed({9'b0, s4_40_r});
    s5x      = $signed({9'b0, s5_40_r});
    p_full   = 40'sd10 * s3x - 40'sd15 * s4x + 40'sd6 * s5x;
    dp_full  = 40'sd30 * s2x - 40'sd60 * s3x + 40'sd30 * s4x;
    ddp_full = 40'sd60 * sx - 40'sd180 * s2x + 40'sd120 * s3x;
    if (p_full < 0) begin
      p_nxt = '0;
    end else if (p_full > (40'sd1 <<< S_BITS)) begin
      p_nxt = S_W'(1) << S_BITS;
    end else begin
      p_nxt = p_full[S_W-1:0];
    end
    dp_nxt   = (dp_full < 0) ? '0 : dp_full[S_W-1:0];
    addr_nxt = (ddp_full < 0) ? DDP_W'(-ddp_full) : DDP_W'(ddp_full);
  end

  always_ff @(posedge clk) begin
    p_41_r      <= p_nxt;
    dp_41_r     <= dp_nxt;
    addr_41_r   <= addr_nxt;
    ddpneg_41_r <= ddp_full < 0;
  end

  // Scale by the distance.
  always_ff @(posedge clk) begin
    pp_42_r   <= PP_W'(sb_r[D_POLY].ad) * PP_W'(p_41_r);
    vp_42_r   <= PP_W'(sb_r[D_POLY].ad) * PP_W'(dp_41_r);
    ap_42_r   <= AP_W'(sb_r[D_POLY].ad) * AP_W'(addr_41_r);
    aneg_42_r <= sb_r[D_POLY].dneg ^ ddpneg_41_r;
  end

  // Round the position offset; apply the first factor of the unit scales.
  always_ff @(posedge clk) begin
    pm_43_r   <= AD_W'((pp_42_r + HALF_S) >> S_BITS);
    vn_43_r   <= VN_W'(vp_42_r) * VN_W'(K5_6);
    an1_43_r  <= AN1_W'(ap_42_r) * AN1_W'(K5_6);
    aneg_43_r <= aneg_42_r;
  end

  // Final position and rate dividends.
  assign pos_nxt = sb_r[D_MUL1].dneg ? (sb_r[D_MUL1].start_pos - pm_43_r)
                                     : (sb_r[D_MUL1].start_pos + pm_43_r);

  always_ff @(posedge clk) begin
    vm_44_r        <= VM_W'((VSUM_W'(vn_43_r) + (VSUM_W'(dur_r) << (FRAC_BITS + 7)))
                            >> (FRAC_BITS + 8));
    an2_44_r       <= AN2_W'(an1_43_r) * AN2_W'(K5_6);
    late_r[D_MUL2] <= '{pos: pos_nxt, aneg: aneg_43_r};
  end

  always_ff @(posedge clk) begin
    vm_45_r <= vm_44_r;
    ax_45_r <= AX_W'((ASUM_W'(an2_44_r) + (ASUM_W'(tsq_r) << (FRAC_BITS + 1)))
                     >> (FRAC_BITS + 2));
  end

  for (genvar k = D_MUL2 + 1; k <= D_RATE; k++) begin : g_late
    always_ff @(posedge clk) begin
      late_r[k] <= late_r[k-1];
    end
  end

  // Velocity magnitude: divide by T after the 2^(FRAC_BITS+8) scaling.
  mjt_div u_div_v (
    .clk (clk),
    .num (DIV_NUM_W'(vm_45_r)),
    .den (DIV_DEN_W'(dur_r)),
    .quo (v_quo),
    .ovf (v_ovf)
  );

  // Acceleration magnitude: divide by T squared.
  mjt_div u_div_a (
    .clk (clk),
    .num (DIV_NUM_W'(ax_45_r)),
    .den (tsq_r),
    .quo (a_quo),
    .ovf (a_ovf)
  );

  // Sign, saturation and status.
  assign sb_end   = sb_r[D_RATE];
  assign late_end = late_r[D_RATE];
  assign v_sat    = sat_rate(v_quo, v_ovf, sb_end.dneg);
  assign a_sat    = sat_rate(a_quo, a_ovf, late_end.aneg);

  always_ff @(posedge clk) begin
    if (sb_end.zero) begin
      out_position_r     <= sb_end.end_pos;
      out_velocity_r     <= '0;
      out_acceleration_r <= '0;
      out_status_r       <= ST_ZERO_DUR;
    end else begin
      out_position_r     <= late_end.pos;
      out_velocity_r     <= v_sat[RATE_W-1:0];
      out_acceleration_r <= a_sat[RATE_W-1:0];
      if (v_sat[RATE_W] || a_sat[RATE_W]) begin
        out_status_r <= ST_SAT;
      end else if (sb_end.clamped) begin
        out_status_r <= ST_CLAMPED;
      end else begin
        out_status_r <= ST_OK;
      end
    end
  end

  assign out_strobe       = v_r[D_OUT];
  assign out_position     = out_position_r;
  assign out_velocity     = out_velocity_r;
  assign out_acceleration = out_acceleration_r;
  assign out_status       = out_status_r;

  // Every strobed result has a matching accepted request.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, D_OUT))
    else $error("result without a matching request");

  // The s divider can only overflow when the duration is zero.
  a_s_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[D_S] && s_ovf) |-> sb_r[D_S].zero)
    else $error("s divider overflow with nonzero duration");

  // A zero duration gives zero rates.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ST_ZERO_DUR)) |->
      ((out_velocity == '0) && (out_acceleration == '0)))
    else $error("nonzero rate with zero duration");

  // Past the end of the motion (clamped status) the rates are zero.
  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ST_CLAMPED)) |->
      ((out_velocity == '0) && (out_acceleration == '0)))
    else $error("nonzero rate after the end of the motion");

  // Reset flushes the pipeline.
  a_flush: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result right after reset");

endmodule

@@ hdl/mjt_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage. Gives floor(num / den) on 33 bits
// and flags a quotient that does not fit.
// ----------------------------------------------------------------------------
module mjt_div
  import mjt_pkg::*;
(
  input  logic                 clk,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_Q_W-1:0]   quo,
  output logic                 ovf
);

  logic [DIV_DEN_W-1:0] rem_r [0:DIV_Q_W-1];
  logic [DIV_Q_W-1:0]   low_r [0:DIV_Q_W-1];
  logic [DIV_Q_W-1:0]   quo_r [0:DIV_Q_W];
  logic [DIV_Q_W:0]     ovf_r;
  logic [DIV_DEN_W:0]   trial [0:DIV_Q_W-1];
  logic [DIV_Q_W-1:0]   fits;
  logic [DIV_DEN_W-1:0] rem_nxt [0:DIV_Q_W-1];

  // Entry stage: the high part of the dividend is the first remainder.
  // A high part that already reaches the divisor means the quotient overflows.
  always_ff @(posedge clk) begin
    rem_r[0] <= DIV_DEN_W'(num >> DIV_Q_W);
    low_r[0] <= num[DIV_Q_W-1:0];
    quo_r[0] <= '0;
    ovf_r[0] <= (num >> DIV_Q_W) >= DIV_NUM_W'(den);
  end

  // One trial subtraction per stage.
  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
    assign trial[k]   = {rem_r[k], low_r[k][DIV_Q_W-1]};
    assign fits[k]    = trial[k] >= {1'b0, den};
    assign rem_nxt[k] = fits[k] ? DIV_DEN_W'(trial[k] - {1'b0, den})
                                : DIV_DEN_W'(trial[k]);

    always_ff @(posedge clk) begin
      quo_r[k+1]   <= {quo_r[k][DIV_Q_W-2:0], fits[k]};
      ovf_r[k+1]   <= ovf_r[k];
    end

    if (k < DIV_Q_W - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        rem_r[k+1] <= rem_nxt[k];
        low_r[k+1] <= low_r[k] << 1;
      end
    end
  end

  assign quo = quo_r[DIV_Q_W];
  assign ovf = ovf_r[DIV_Q_W];

endmodule

@@ bench/mjt_checker.sv @@
// ----------------------------------------------------------------------------
// Minimum-jerk trajectory checker
// Watches the request, result and configuration channels of the trajectory
// unit, predicts every result from its own model of the quintic profile and
// compares each strobed result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module mjt_checker
  import mjt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic signed [POS_W-1:0]  in_start_pos,
  input  logic signed [POS_W-1:0]  in_end_pos,
  input  logic [TIME_W-1:0]        in_time_us,
  input  logic                     out_strobe,
  input  logic signed [POS_W-1:0]  out_position,
  input  logic signed [RATE_W-1:0] out_velocity,
  input  logic signed [RATE_W-1:0] out_acceleration,
  input  logic [STAT_W-1:0]        out_status,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [TIME_W-1:0]        cfg_duration_us,
  output int                       fail_count,
  output int                       pending
);

  typedef struct {
    logic [POS_W-1:0]  position;
    logic [RATE_W-1:0] velocity;
    logic [RATE_W-1:0] acceleration;
    status_t           status;
  } sample_t;

  localparam longint unsigned RATE_CAP = 64'd1 << 62;

  sample_t         sample_q[$];
  logic [TIME_W-1:0] duration;

  // Sign a rate magnitude and clip it to the 32-bit field.
  function automatic logic [RATE_W-1:0] clip_rate(input longint unsigned mag,
                                                  input logic neg,
                                                  inout logic clipped);
    if (neg) begin
      if (mag > 64'h80000000) begin
        mag = 64'h80000000;
        clipped = 1'b1;
      end
      return RATE_W'(64'd0 - mag);
    end
    if (mag > 64'h7FFFFFFF) begin
      mag = 64'h7FFFFFFF;
      clipped = 1'b1;
    end
    return RATE_W'(mag);
  endfunction

  // Predict one joint sample of the quintic profile.
  function automatic sample_t quintic_sample(input logic signed [POS_W-1:0] sp,
                                             input logic signed [POS_W-1:0] ep,
                                             input logic [TIME_W-1:0] tu,
                                             input logic [TIME_W-1:0] dur);
    sample_t r;
    longint d, p, dp, ddp;
    longint unsigned ad, tc, tt, s, s2, s3, s4, s5, pm, vmag, amag, addr, den;
    logic [127:0] num, q;
    logic clamped, clipped;
    tt = dur;
    tc = tu;
    d = longint'(ep) - longint'(sp);
    ad = (d < 0) ? -d : d;
    clamped = 1'b0;
    clipped = 1'b0;
    if (tt == 0) begin
      r.position = ep;
      r.velocity = '0;
      r.acceleration = '0;
      r.status = ST_ZERO_DUR;
      return r;
    end
    if (tc > tt) begin
      tc = tt;
      clamped = 1'b1;
    end
    s = (tc << S_BITS) / tt;
    s2 = (s * s) >> S_BITS;
    s3 = (s2 * s) >> S_BITS;
    s4 = (s3 * s) >> S_BITS;
    s5 = (s4 * s) >> S_BITS;
    p = 10 * longint'(s3) - 15 * longint'(s4) + 6 * longint'(s5);
    if (p < 0) p = 0;
    if (p > (longint'(1) << S_BITS)) p = longint'(1) << S_BITS;
    dp = 30 * longint'(s2) - 60 * longint'(s3) + 30 * longint'(s4);
    if (dp < 0) dp = 0;
    ddp = 60 * longint'(s) - 180 * longint'(s2) + 120 * longint'(s3);

    // Position rounds half away from zero along the direction of travel.
    pm = (ad * longint'(p) + (64'd1 << (S_BITS - 1))) >> S_BITS;
    r.position = POS_W'((d < 0) ? longint'(sp) - longint'(pm) : longint'(sp) + longint'(pm));

    // Velocity: |d| * dp * 10^6 / (T * 2^(FRAC_BITS+14)), folded into 5^6.
    den = tt << (FRAC_BITS + 8);
    num = 128'(ad) * 128'(dp) * 128'(15625) + 128'(den >> 1);
    q = num / 128'(den);
    vmag = (q > 128'(RATE_CAP)) ? RATE_CAP : longint'(q[63:0]);
    r.velocity = clip_rate(vmag, (d < 0) && (vmag != 0), clipped);

    // Acceleration: |d| * |ddp| * 5^12 / T^2, then a rounded shift.
    addr = (ddp < 0) ? -ddp : ddp;
    num = 128'(ad) * 128'(addr) * 128'(244140625);
    q = num / (128'(tt) * 128'(tt));
    amag = (q > 128'(RATE_CAP)) ? RATE_CAP : longint'(q[63:0]);
    amag = (amag + (64'd1 << (FRAC_BITS + 1))) >> (FRAC_BITS + 2);
    r.acceleration = clip_rate(amag, ((d < 0) != (ddp < 0)) && (amag != 0), clipped);

    r.status = clipped ? ST_SAT : (clamped ? ST_CLAMPED : ST_OK);
    return r;
  endfunction

  assign pending = sample_q.size();

  // Track the duration register, predict on each request, check each result.
  always @(posedge clk) begin
    sample_t exp_s;
    if (!rst_n) begin
      duration <= TIME_W'(1000000);
      sample_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        duration <= cfg_duration_us;
      end
      if (start && !busy) begin
        sample_q.push_back(quintic_sample(in_start_pos, in_end_pos, in_time_us, duration));
      end
      if (out_strobe) begin
        if (sample_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          exp_s = sample_q.pop_front();
          if (out_position !== exp_s.position ||
              out_velocity !== exp_s.velocity ||
              out_acceleration !== exp_s.acceleration ||
              out_status !== exp_s.status) begin
            fail_count <= fail_count + 1;
          end
          if (out_position !== exp_s.position) begin
            $error("position expected %h actual %h", exp_s.position, out_position);
          end
          if (out_velocity !== exp_s.velocity) begin
            $error("velocity expected %h actual %h", exp_s.velocity, out_velocity);
          end
          if (out_acceleration !== exp_s.acceleration) begin
            $error("acceleration expected %h actual %h", exp_s.acceleration,
                   out_acceleration);
          end
          if (out_status !== exp_s.status) begin
            $error("status expected %0d actual %0d", exp_s.status, out_status);
          end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Minimum-jerk trajectory unit testbench
// Drives joint sample requests in random bursts over several motion
// durations, including zero and the largest, while a checker module
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import mjt_pkg::*;

  localparam int RANDOM_PER_PHASE = 110;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [POS_W-1:0]  in_start_pos;
  logic signed [POS_W-1:0]  in_end_pos;
  logic [TIME_W-1:0]        in_time_us;
  logic                     out_strobe;
  logic signed [POS_W-1:0]  out_position;
  logic signed [RATE_W-1:0] out_velocity;
  logic signed [RATE_W-1:0] out_acceleration;
  logic [STAT_W-1:0]        out_status;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [TIME_W-1:0]        cfg_duration_us;
  int                       fail_count;
  int                       pending;

  logic [TIME_W-1:0] cur_dur;
  int                burst_left;
  int                sent;

  min_jerk_joint_trajectory_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_pos(in_start_pos), .in_end_pos(in_end_pos), .in_time_us(in_time_us),
    .out_strobe(out_strobe), .out_position(out_position),
    .out_velocity(out_velocity), .out_acceleration(out_acceleration),
    .out_status(out_status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_duration_us(cfg_duration_us)
  );

  mjt_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_pos(in_start_pos), .in_end_pos(in_end_pos), .in_time_us(in_time_us),
    .out_strobe(out_strobe), .out_position(out_position),
    .out_velocity(out_velocity), .out_acceleration(out_acceleration),
    .out_status(out_status), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_duration_us(cfg_duration_us), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Present one request and hold it until the unit takes it. A gap between
  // bursts lowers start for a random number of cycles first.
  task automatic send_request(input logic [POS_W-1:0] sp, input logic [POS_W-1:0] ep,
                              input logic [TIME_W-1:0] tu);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left = burst_left - 1;
    start <= 1'b1;
    in_start_pos <= sp;
    in_end_pos <= ep;
    in_time_us <= tu;
    do @(negedge clk); while (busy);
    @(posedge clk);
    sent = sent + 1;
  endtask

  // Let every outstanding result arrive.
  task automatic drain;
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Write the duration register while the unit is idle.
  task automatic set_duration(input logic [TIME_W-1:0] dur);
    drain();
    cfg_valid <= 1'b1;
    cfg_duration_us <= dur;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    cur_dur = dur;
  endtask

  // Random time: mostly inside the motion, some at or past its end.
  function automatic logic [TIME_W-1:0] pick_time(input logic [TIME_W-1:0] dur);
    case ($urandom_range(0, 9))
      0: return TIME_W'($urandom);
      1: return dur;
      2: return (dur == '1) ? dur : dur + TIME_W'($urandom_range(1, 1000));
      default: return TIME_W'($urandom_range(0, dur));
    endcase
  endfunction

  // Random positions: full range, nearby pairs or equal pairs.
  task automatic random_request;
    logic [POS_W-1:0] sp;
    logic [POS_W-1:0] ep;
    sp = POS_W'($urandom);
    case ($urandom_range(0, 5))
      0: ep = sp;
      1, 2: ep = sp + POS_W'($urandom_range(0, 8191)) - POS_W'(4096);
      default: ep = POS_W'($urandom);
    endcase
    send_request(sp, ep, pick_time(cur_dur));
  endtask

  // Extreme, null and unit moves at times from the start to past the end.
  task automatic directed_requests;
    send_request(24'h800000, 24'h7FFFFF, '0);
    send_request(24'h800000, 24'h7FFFFF, cur_dur >> 1);
    send_request(24'h7FFFFF, 24'h800000, cur_dur >> 2);
    send_request(24'h7FFFFF, 24'h800000, cur_dur);
    send_request(24'h000000, 24'h000000, cur_dur >> 1);
    send_request(24'h123456, 24'h123457, cur_dur >> 1);
    send_request(24'h800000, 24'h7FFFFF, '1);
  endtask

  initial begin
    logic [TIME_W-1:0] durs [6];
    rst_n = 1'b0;
    start = 1'b0;
    in_start_pos = '0;
    in_end_pos = '0;
    in_time_us = '0;
    cfg_valid = 1'b0;
    cfg_duration_us = '0;
    burst_left = 0;
    sent = 0;
    cur_dur = TIME_W'(1000000);
    durs[0] = TIME_W'(7);
    durs[1] = '0;
    durs[2] = '1;
    durs[3] = TIME_W'(1);
    durs[4] = TIME_W'($urandom_range(2, 5000));
    durs[5] = TIME_W'($urandom_range(5001, 67108863));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset duration first, then each of the other settings.
    directed_requests();
    for (int i = 0; i < RANDOM_PER_PHASE; i++) random_request();
    for (int ph = 0; ph < 6; ph++) begin
      set_duration(durs[ph]);
      directed_requests();
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (i == RANDOM_PER_PHASE / 2 && ph == 2) drain();
        random_request();
      end
    end

    drain();
    repeat (D_OUT + 20) @(posedge clk);
    $display("Covered %0d requests over seven motion durations, including zero,", sent);
    $display("one microsecond, the largest, and times before, at and past the end.");
    if (fail_count == 0) begin
      $display("min_jerk_joint_trajectory_unit test passed");
    end else begin
      $display("min_jerk_joint_trajectory_unit test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("min_jerk_joint_trajectory_unit test failed");
    $finish;
  end

endmodule
